// File: hw/rtl/cpag_pkg.sv
package cpag_pkg;

  localparam int ADDR_W     = 48;
  localparam int IDX_W      = 32;
  localparam int DIV_W      = 50;
  localparam int DVS_W      = 13;
  localparam int DIV_CNT_W  = 6;
  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 24;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 432;
  localparam int OUT_USER_W = 2;
  localparam int BUF_N      = 8;

  localparam logic [ADDR_W-1:0] OFS_STEP = ADDR_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_SIZE    = 3'd0,
    CFG_KERNEL_SIZE   = 3'd1,
    CFG_CHANNEL_COUNT = 3'd2,
    CFG_STEP_SIZE     = 3'd3,
    CFG_KERNEL_COUNT  = 3'd4,
    CFG_IMAGE_COUNT   = 3'd5,
    CFG_UNIT_SPACING  = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD, OP_KER, OP_COL, OP_SROW, OP_NROW, OP_STORE, OP_FINISH
  } dp_op_t;

  typedef enum logic [2:0] {
    DV_RANK, DV_KIDX, DV_QS, DV_COLQS, DV_ROWQS
  } div_src_t;

  typedef enum logic [1:0] {
    DS_KC, DS_IMG, DS_SP
  } div_dvs_t;

  typedef enum logic [3:0] {
    MU_NONE, MU_DIMX, MU_KK, MU_DIMY, MU_DIMF,
    MU_IMGLO, MU_IMGHI, MU_ROW, MU_COL, MU_KLO, MU_KHI
  } mul_op_t;

  typedef enum logic [1:0] {
    RK_START, RK_DONE, RK_GROUP
  } res_kind_t;

  typedef struct packed {
    dp_op_t    op;
    logic      div_start;
    div_src_t  div_src;
    div_dvs_t  div_dvs;
    mul_op_t   mul_op;
    logic      ld_out;
    res_kind_t out_kind;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sp_zero;
    logic fin;
    logic fill_last;
    logic walk_over;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/cpag_div.sv
module cpag_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cpag_pkg::DIV_W-1:0] dividend,
  input  logic [cpag_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [cpag_pkg::DIV_W-1:0] quot,
  output logic [cpag_pkg::DVS_W-1:0] rem
);

  logic [cpag_pkg::DIV_W-1:0]     q_r;
  logic [cpag_pkg::DVS_W-1:0]     r_r;
  logic [cpag_pkg::DVS_W-1:0]     d_r;
  logic [cpag_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic                           quick;
  logic [cpag_pkg::DVS_W:0]       shifted;
  logic [cpag_pkg::DVS_W+1:0]     diff;
  logic                           ge;
  logic [cpag_pkg::DVS_W-1:0]     r_nxt;

  assign quick   = dividend < {{(cpag_pkg::DIV_W-cpag_pkg::DVS_W){1'b0}}, divisor};
  assign shifted = {r_r, q_r[cpag_pkg::DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, d_r};
  assign ge      = ~diff[cpag_pkg::DVS_W+1];
  assign r_nxt   = ge ? diff[cpag_pkg::DVS_W-1:0] : shifted[cpag_pkg::DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= '0;
        if (quick) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == cpag_pkg::DIV_CNT_W'(cpag_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      d_r <= divisor;
      if (quick) begin
        q_r <= '0;
        r_r <= dividend[cpag_pkg::DVS_W-1:0];
      end else begin
        q_r <= dividend;
        r_r <= '0;
      end
    end else if (busy_r) begin
      r_r <= r_nxt;
      q_r <= {q_r[cpag_pkg::DIV_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

// File: hw/rtl/cpag_dp.sv
module cpag_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cpag_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpag_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [9:0]                       rank,
  input  logic [cpag_pkg::ADDR_W-1:0]      img_base,
  input  logic [cpag_pkg::ADDR_W-1:0]      ker_base,
  input  logic [cpag_pkg::ADDR_W-1:0]      res_base,
  input  cpag_pkg::cmd_t                   cmd,
  output cpag_pkg::sts_t                   sts,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [cpag_pkg::OUT_DATA_W-1:0]  out_data,
  output logic [cpag_pkg::OUT_USER_W-1:0]  out_user
);

  localparam int AW = cpag_pkg::ADDR_W;
  localparam int IW = cpag_pkg::IDX_W;
  localparam int DW = cpag_pkg::DIV_W;

  logic [10:0] image_size_r, kernel_size_r, unit_spacing_r;
  logic [12:0] channel_count_r, kernel_count_r;
  logic [7:0]  step_size_r;
  logic [15:0] image_count_r;

  logic [10:0] img_nz, us_nz;
  logic [12:0] kc_nz;
  logic [11:0] span_a, sp;
  logic [12:0] leap;

  logic [IW-1:0] kidx_r, col_r, row_r, img_idx_r;
  logic [1:0]    fill_r;
  logic          walk_over_r;
  logic          fin_r;
  logic [AW-1:0] offset_r;
  logic [AW-1:0] base0_r, base1_r, base2_r;
  logic [DW-1:0] qs_r;

  logic [DW-1:0]              dvd;
  logic [cpag_pkg::DVS_W-1:0] dvs;
  logic                       div_done;
  logic [DW-1:0]              quot;
  logic [cpag_pkg::DVS_W-1:0] rem;
  logic [DW+7:0]              qs_prod;
  logic [DW:0]                i_sum;

  logic [cpag_pkg::MUL_A_W-1:0] mul_a;
  logic [cpag_pkg::MUL_B_W-1:0] mul_b;
  logic [cpag_pkg::PROD_W-1:0]  prod_r;
  cpag_pkg::mul_op_t            mop_r;
  logic [23:0]                  dimx_r;
  logic [21:0]                  kk_r;
  logic [34:0]                  dimy_r, dimf_r;
  logic [AW-1:0]                accp_r, acck_r;
  logic [AW-1:0]                buf_r [cpag_pkg::BUF_N];

  logic                           out_valid_r;
  logic [cpag_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [cpag_pkg::OUT_USER_W-1:0] out_user_r;
  logic                            out_free;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r    <= 11'd1;
      kernel_size_r   <= 11'd1;
      channel_count_r <= 13'd1;
      step_size_r     <= 8'd1;
      kernel_count_r  <= 13'd1;
      image_count_r   <= 16'd1;
      unit_spacing_r  <= 11'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        cpag_pkg::CFG_IMAGE_SIZE:    image_size_r    <= cfg_wdata[10:0];
        cpag_pkg::CFG_KERNEL_SIZE:   kernel_size_r   <= cfg_wdata[10:0];
        cpag_pkg::CFG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[12:0];
        cpag_pkg::CFG_STEP_SIZE:     step_size_r     <= cfg_wdata[7:0];
        cpag_pkg::CFG_KERNEL_COUNT:  kernel_count_r  <= cfg_wdata[12:0];
        cpag_pkg::CFG_IMAGE_COUNT:   image_count_r   <= cfg_wdata[15:0];
        cpag_pkg::CFG_UNIT_SPACING:  unit_spacing_r  <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // zero image size, kernel count and unit spacing act as one
  assign img_nz = (image_size_r == '0) ? 11'd1 : image_size_r;
  assign kc_nz  = (kernel_count_r == '0) ? 13'd1 : kernel_count_r;
  assign us_nz  = (unit_spacing_r == '0) ? 11'd1 : unit_spacing_r;
  assign span_a = {1'b0, img_nz} + {4'b0000, step_size_r};
  assign sp     = ({1'b0, kernel_size_r} >= span_a) ? 12'd0 : span_a - {1'b0, kernel_size_r};
  assign leap   = {us_nz - 11'd1, 2'b01};

  always_comb begin
    case (cmd.div_src)
      cpag_pkg::DV_RANK:  dvd = {{(DW-12){1'b0}}, rank, 2'b00};
      cpag_pkg::DV_KIDX:  dvd = {{(DW-IW){1'b0}}, kidx_r};
      cpag_pkg::DV_QS:    dvd = qs_r;
      cpag_pkg::DV_COLQS: dvd = {{(DW-IW){1'b0}}, col_r} + qs_r;
      cpag_pkg::DV_ROWQS: dvd = {{(DW-IW){1'b0}}, row_r} + qs_r;
      default:            dvd = '0;
    endcase
    case (cmd.div_dvs)
      cpag_pkg::DS_KC:  dvs = kc_nz;
      cpag_pkg::DS_IMG: dvs = {2'b00, img_nz};
      cpag_pkg::DS_SP:  dvs = {1'b0, sp};
      default:          dvs = kc_nz;
    endcase
  end

  cpag_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  assign qs_prod = quot * step_size_r;
  assign i_sum   = {{(DW+1-IW){1'b0}}, img_idx_r} + {1'b0, quot};

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_op)
      cpag_pkg::MU_DIMX: begin
        mul_a = {21'b0, img_nz};
        mul_b = {11'b0, channel_count_r};
      end
      cpag_pkg::MU_KK: begin
        mul_a = {21'b0, kernel_size_r};
        mul_b = {13'b0, kernel_size_r};
      end
      cpag_pkg::MU_DIMY: begin
        mul_a = {21'b0, img_nz};
        mul_b = dimx_r;
      end
      cpag_pkg::MU_DIMF: begin
        mul_a = {10'b0, kk_r};
        mul_b = {11'b0, channel_count_r};
      end
      cpag_pkg::MU_IMGLO: begin
        mul_a = img_idx_r;
        mul_b = dimy_r[23:0];
      end
      cpag_pkg::MU_IMGHI: begin
        mul_a = img_idx_r;
        mul_b = {13'b0, dimy_r[34:24]};
      end
      cpag_pkg::MU_ROW: begin
        mul_a = row_r;
        mul_b = dimx_r;
      end
      cpag_pkg::MU_COL: begin
        mul_a = col_r;
        mul_b = {11'b0, channel_count_r};
      end
      cpag_pkg::MU_KLO: begin
        mul_a = kidx_r;
        mul_b = dimf_r[23:0];
      end
      cpag_pkg::MU_KHI: begin
        mul_a = kidx_r;
        mul_b = {13'b0, dimf_r[34:24]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign out_free = ~out_valid_r | out_ready;

  // walk state and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kidx_r      <= '0;
      col_r       <= '0;
      row_r       <= '0;
      img_idx_r   <= '0;
      fill_r      <= '0;
      offset_r    <= '0;
      walk_over_r <= 1'b1;
      out_valid_r <= 1'b0;
      mop_r       <= cpag_pkg::MU_NONE;
    end else begin
      mop_r <= cmd.mul_op;
      case (cmd.op)
        cpag_pkg::OP_LOAD: begin
          fill_r      <= '0;
          offset_r    <= '0;
          walk_over_r <= 1'b0;
        end
        cpag_pkg::OP_KER:  kidx_r <= {{(IW-cpag_pkg::DVS_W){1'b0}}, rem};
        cpag_pkg::OP_COL:  col_r  <= {{(IW-cpag_pkg::DVS_W){1'b0}}, rem};
        cpag_pkg::OP_SROW: begin
          row_r     <= {{(IW-cpag_pkg::DVS_W){1'b0}}, rem};
          img_idx_r <= quot[IW-1:0];
        end
        cpag_pkg::OP_NROW: begin
          row_r     <= {{(IW-cpag_pkg::DVS_W){1'b0}}, rem};
          img_idx_r <= i_sum[IW-1:0];
        end
        cpag_pkg::OP_STORE: begin
          if (fill_r != 2'd3) begin
            fill_r <= fill_r + 2'd1;
            kidx_r <= kidx_r + 1'b1;
          end
        end
        cpag_pkg::OP_FINISH: begin
          walk_over_r <= 1'b1;
          fill_r      <= '0;
        end
        default: ;
      endcase
      if (cmd.ld_out) begin
        out_valid_r <= 1'b1;
        if (cmd.out_kind == cpag_pkg::RK_GROUP) begin
          fill_r   <= '0;
          offset_r <= offset_r + cpag_pkg::OFS_STEP;
          kidx_r   <= kidx_r + {{(IW-13){1'b0}}, leap};
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (cmd.op == cpag_pkg::OP_LOAD) begin
      base0_r <= img_base;
      base1_r <= ker_base;
      base2_r <= res_base;
    end
    if (cmd.op == cpag_pkg::OP_KER || cmd.op == cpag_pkg::OP_COL) begin
      qs_r <= qs_prod[DW-1:0];
    end
    if (cmd.op == cpag_pkg::OP_NROW) begin
      fin_r <= i_sum >= {{(DW+1-16){1'b0}}, image_count_r};
    end
    if (cmd.op == cpag_pkg::OP_STORE) begin
      buf_r[{fill_r, 1'b0}] <= base0_r + {accp_r[AW-2:0], 1'b0};
      buf_r[{fill_r, 1'b1}] <= base1_r + {acck_r[AW-2:0], 1'b0};
    end

    prod_r <= mul_a * mul_b;
    case (mop_r)
      cpag_pkg::MU_DIMX:  dimx_r <= prod_r[23:0];
      cpag_pkg::MU_KK:    kk_r   <= prod_r[21:0];
      cpag_pkg::MU_DIMY:  dimy_r <= prod_r[34:0];
      cpag_pkg::MU_DIMF:  dimf_r <= prod_r[34:0];
      cpag_pkg::MU_IMGLO: accp_r <= prod_r[AW-1:0];
      cpag_pkg::MU_IMGHI: accp_r <= accp_r + {prod_r[AW-25:0], 24'b0};
      cpag_pkg::MU_ROW:   accp_r <= accp_r + prod_r[AW-1:0];
      cpag_pkg::MU_COL:   accp_r <= accp_r + prod_r[AW-1:0];
      cpag_pkg::MU_KLO:   acck_r <= prod_r[AW-1:0];
      cpag_pkg::MU_KHI:   acck_r <= acck_r + {prod_r[AW-25:0], 24'b0};
      default: ;
    endcase

    if (cmd.ld_out) begin
      case (cmd.out_kind)
        cpag_pkg::RK_GROUP: begin
          out_data_r <= {base2_r + offset_r, buf_r[7], buf_r[6], buf_r[5], buf_r[4],
                         buf_r[3], buf_r[2], buf_r[1], buf_r[0]};
          out_user_r <= 2'b10;
        end
        cpag_pkg::RK_DONE: begin
          out_data_r <= '0;
          out_user_r <= 2'b01;
        end
        default: begin
          out_data_r <= '0;
          out_user_r <= 2'b00;
        end
      endcase
    end
  end

  assign sts.div_done  = div_done;
  assign sts.sp_zero   = (sp == '0);
  assign sts.fin       = fin_r;
  assign sts.fill_last = (fill_r == 2'd3);
  assign sts.walk_over = walk_over_r;
  assign sts.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_user  = out_user_r;

endmodule

// File: hw/rtl/cpag_ctrl.sv
module cpag_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_func,
  output logic           in_ready,
  input  cpag_pkg::sts_t sts,
  output cpag_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    IDLE,
    S_W1, S_KER, S_P, S_W2, S_COL, S_Q, S_W3, S_ROW,
    D_DIMX, D_KK, D_DIMY, D_DIMF,
    N_KIDX, N_W1, N_KER, N_X, N_W2, N_COL, N_Y, N_W3, N_ROW, N_CHK,
    A_IMGLO, A_IMGHI, A_ROW, A_COL, A_KLO, A_KHI, A_DRAIN, A_STORE,
    RESP
  } state_t;

  state_t              state_r, state_nxt;
  cpag_pkg::res_kind_t kind_r, kind_nxt;

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    in_ready     = 1'b0;
    cmd.op       = cpag_pkg::OP_NONE;
    cmd.div_start = 1'b0;
    cmd.div_src  = cpag_pkg::DV_KIDX;
    cmd.div_dvs  = cpag_pkg::DS_KC;
    cmd.mul_op   = cpag_pkg::MU_NONE;
    cmd.ld_out   = 1'b0;
    cmd.out_kind = kind_r;
    case (state_r)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_func) begin
            cmd.op        = cpag_pkg::OP_LOAD;
            cmd.div_start = 1'b1;
            cmd.div_src   = cpag_pkg::DV_RANK;
            state_nxt     = S_W1;
          end else if (sts.walk_over) begin
            kind_nxt  = cpag_pkg::RK_DONE;
            state_nxt = RESP;
          end else begin
            state_nxt = D_DIMX;
          end
        end
      end
      S_W1: if (sts.div_done) state_nxt = S_KER;
      S_KER: begin
        cmd.op    = cpag_pkg::OP_KER;
        state_nxt = S_P;
      end
      S_P: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = cpag_pkg::DV_QS;
        cmd.div_dvs   = cpag_pkg::DS_IMG;
        state_nxt     = S_W2;
      end
      S_W2: if (sts.div_done) state_nxt = S_COL;
      S_COL: begin
        cmd.op    = cpag_pkg::OP_COL;
        state_nxt = S_Q;
      end
      S_Q: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = cpag_pkg::DV_QS;
        cmd.div_dvs   = cpag_pkg::DS_IMG;
        state_nxt     = S_W3;
      end
      S_W3: if (sts.div_done) state_nxt = S_ROW;
      S_ROW: begin
        cmd.op    = cpag_pkg::OP_SROW;
        kind_nxt  = cpag_pkg::RK_START;
        state_nxt = RESP;
      end
      // element counts for this request
      D_DIMX: begin
        cmd.mul_op = cpag_pkg::MU_DIMX;
        state_nxt  = D_KK;
      end
      D_KK: begin
        cmd.mul_op = cpag_pkg::MU_KK;
        state_nxt  = D_DIMY;
      end
      D_DIMY: begin
        cmd.mul_op = cpag_pkg::MU_DIMY;
        state_nxt  = D_DIMF;
      end
      D_DIMF: begin
        cmd.mul_op = cpag_pkg::MU_DIMF;
        state_nxt  = N_KIDX;
      end
      // carry filter -> col -> row -> image
      N_KIDX: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = cpag_pkg::DV_KIDX;
        cmd.div_dvs   = cpag_pkg::DS_KC;
        state_nxt     = N_W1;
      end
      N_W1: if (sts.div_done) state_nxt = N_KER;
      N_KER: begin
        cmd.op    = cpag_pkg::OP_KER;
        state_nxt = N_X;
      end
      N_X: begin
        if (sts.sp_zero) begin
          cmd.op    = cpag_pkg::OP_FINISH;
          kind_nxt  = cpag_pkg::RK_DONE;
          state_nxt = RESP;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_src   = cpag_pkg::DV_COLQS;
          cmd.div_dvs   = cpag_pkg::DS_SP;
          state_nxt     = N_W2;
        end
      end
      N_W2: if (sts.div_done) state_nxt = N_COL;
      N_COL: begin
        cmd.op    = cpag_pkg::OP_COL;
        state_nxt = N_Y;
      end
      N_Y: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = cpag_pkg::DV_ROWQS;
        cmd.div_dvs   = cpag_pkg::DS_SP;
        state_nxt     = N_W3;
      end
      N_W3: if (sts.div_done) state_nxt = N_ROW;
      N_ROW: begin
        cmd.op    = cpag_pkg::OP_NROW;
        state_nxt = N_CHK;
      end
      N_CHK: begin
        if (sts.fin) begin
          cmd.op    = cpag_pkg::OP_FINISH;
          kind_nxt  = cpag_pkg::RK_DONE;
          state_nxt = RESP;
        end else begin
          state_nxt = A_IMGLO;
        end
      end
      A_IMGLO: begin
        cmd.mul_op = cpag_pkg::MU_IMGLO;
        state_nxt  = A_IMGHI;
      end
      A_IMGHI: begin
        cmd.mul_op = cpag_pkg::MU_IMGHI;
        state_nxt  = A_ROW;
      end
      A_ROW: begin
        cmd.mul_op = cpag_pkg::MU_ROW;
        state_nxt  = A_COL;
      end
      A_COL: begin
        cmd.mul_op = cpag_pkg::MU_COL;
        state_nxt  = A_KLO;
      end
      A_KLO: begin
        cmd.mul_op = cpag_pkg::MU_KLO;
        state_nxt  = A_KHI;
      end
      A_KHI: begin
        cmd.mul_op = cpag_pkg::MU_KHI;
        state_nxt  = A_DRAIN;
      end
      A_DRAIN: state_nxt = A_STORE;
      A_STORE: begin
        cmd.op = cpag_pkg::OP_STORE;
        if (sts.fill_last) begin
          kind_nxt  = cpag_pkg::RK_GROUP;
          state_nxt = RESP;
        end else begin
          state_nxt = N_KIDX;
        end
      end
      RESP: begin
        // hold until the output register frees up
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      kind_r  <= cpag_pkg::RK_START;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

// File: hw/rtl/conv_patch_address_generator.sv
// Strided convolution address generator.
// Input channel in_*: one transaction per command. in_tuser is the command
// (0 start a job, 1 request the next group). A start carries the unit rank
// and the image, filter and output base addresses in in_tdata.
// Output channel out_*: exactly one transaction per command. A group carries
// four patch/filter address pairs and the output address; out_tuser marks a
// finished walk or a valid group. Start results and done results are zero.
// Configuration: cfg_we with cfg_index/cfg_wdata, written while idle.
// Flow: a command is taken only when the controller is idle. Every division
// runs on one shared radix-2 divider, which skips its bit loop when the
// dividend is below the divisor. A start takes 3 divisions. A request takes,
// per application (up to four per group), 3 divisions and a run of multiplies;
// the divider sets the rate. A request after the walk is over is answered done
// without a division. A command whose result waits in the output register can
// still be accepted; the block then holds its next result until the receiver
// takes the previous one. At reset the walk is over (requests answer done), all
// configuration registers read 1 and no result is pending.
module conv_patch_address_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // unit_rank, image_base, kernel_base, result_base, zero pad
  input  logic [cpag_pkg::IN_DATA_W-1:0]   in_tdata,
  // func
  input  logic [0:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // patch_addr_0, kernel_addr_0, .. patch_addr_3, kernel_addr_3, out_addr
  output logic [cpag_pkg::OUT_DATA_W-1:0]  out_tdata,
  // done_res, group_valid
  output logic [cpag_pkg::OUT_USER_W-1:0]  out_tuser,
  input  logic                             cfg_we,
  input  logic [cpag_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpag_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  cpag_pkg::cmd_t cmd;
  cpag_pkg::sts_t sts;

  cpag_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_func  (in_tuser[0]),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cpag_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rank      (in_tdata[9:0]),
    .img_base  (in_tdata[57:10]),
    .ker_base  (in_tdata[105:58]),
    .res_base  (in_tdata[153:106]),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_user  (out_tuser)
  );

endmodule

// File: hw/rtl/cpag_chk.sv
module cpag_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [cpag_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [cpag_pkg::OUT_USER_W-1:0]  out_tuser
);

  // a result is never both done and a group
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("done and group_valid both set");

  // only a group carries addresses
  a_nongroup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[1]) |-> (out_tdata == '0))
    else $error("non-group result carries addresses");

  // one command in flight at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("command taken while busy");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind conv_patch_address_generator cpag_chk u_cpag_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
